FILE: rtl/sdq_pkg.sv
package sdq_pkg;

    localparam int MAX_SLEEPERS   = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int IDX_W          = $clog2(MAX_SLEEPERS);
    localparam int CNT_W          = $clog2(MAX_SLEEPERS + 1);
    localparam int TIME_W         = 32;
    localparam int DUR_W          = 31;
    localparam int KIND_W         = 2;

    localparam logic [TIME_W-1:0] SIGN_FLIP = {1'b1, {(TIME_W-1){1'b0}}};

    typedef enum logic {
        CMD_CHECK = 1'b0,
        CMD_SLEEP = 1'b1
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_WAKE   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

endpackage

FILE: rtl/sleep_deadline_queue_unit.sv
// Sleep queue of up to MAX_SLEEPERS threads kept in insertion order with their
// wake times. A sleep item is handled in the cycle it is accepted: busy stays low
// and its single result (accepted, or rejected when the queue is full) appears on
// the result ports in the next cycle. A check item holds busy high while it scans
// the queue. One entry is read per cycle from the queue memory's registered read
// port, so its compare in the shared 33-bit adder, which also forms wake times for
// sleep items, comes in the next cycle, and a closing step stores the new entry
// count. Each woken thread gives one result, held back one entry so that the final
// one carries o_last; results follow one another at most one per cycle and the
// last appears in the first cycle with busy low again.
// A check that finds nothing due gives no result. Results are strobed by o_strobe
// for exactly one cycle and cannot be stalled by the receiver.
module sleep_deadline_queue_unit
    import sdq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_command,
    input  logic [7:0]          i_thread_id,
    input  logic [DUR_W-1:0]    i_duration,
    input  logic signed [TIME_W-1:0] i_now,
    output logic                o_strobe,
    output logic [KIND_W-1:0]   o_kind,
    output logic [7:0]          o_woken_id,
    output logic                o_last
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]          r_keep, n_keep;
    logic                      r_rd_valid, n_rd_valid;
    logic [TIME_W-1:0]         r_now;
    logic                      r_pend_valid, n_pend_valid;
    logic [THREAD_ID_BITS-1:0] r_pend_id, n_pend_id;

    logic                      r_strobe, n_strobe;
    t_kind                     r_kind, n_kind;
    logic [7:0]                r_woken_id, n_woken_id;
    logic                      r_last, n_last;

    logic [THREAD_ID_BITS-1:0] r_mem_id   [MAX_SLEEPERS];
    logic [TIME_W-1:0]         r_mem_wake [MAX_SLEEPERS];
    logic [THREAD_ID_BITS-1:0] r_rd_id;
    logic [TIME_W-1:0]         r_rd_wake;

    logic                      accept;
    logic                      rd_issue;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;
    logic [THREAD_ID_BITS-1:0] wr_id;
    logic [TIME_W-1:0]         wr_wake;

    logic [TIME_W:0]           add_a, add_b, add_sum;
    logic                      add_cin;
    logic                      due;
    logic                      full;
    logic [THREAD_ID_BITS-1:0] in_id;

    assign accept  = start && (r_state == ST_IDLE);
    assign busy    = (r_state != ST_IDLE);
    assign full    = (r_count >= CNT_W'(MAX_SLEEPERS));
    assign in_id   = i_thread_id[THREAD_ID_BITS-1:0];
    assign rd_issue = (r_state == ST_SCAN) && (r_rd_idx != r_count);

    // Shared adder: wake time for a sleep, signed compare for a scan.
    // With both sides sign-flipped, now - wake without borrow means wake <= now.
    always_comb begin
        if (r_state == ST_SCAN) begin
            add_a   = {1'b0, r_now ^ SIGN_FLIP};
            add_b   = {1'b0, ~(r_rd_wake ^ SIGN_FLIP)};
            add_cin = 1'b1;
        end else begin
            add_a   = {1'b0, i_now};
            add_b   = {2'b00, i_duration};
            add_cin = 1'b0;
        end
    end

    assign add_sum = add_a + add_b + {{TIME_W{1'b0}}, add_cin};
    assign due     = add_sum[TIME_W];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (t_cmd'(i_command) == CMD_CHECK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!rd_issue && !r_rd_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control and results.
    always_comb begin
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_keep       = r_keep;
        n_rd_valid   = 1'b0;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_strobe     = 1'b0;
        n_kind       = r_kind;
        n_woken_id   = r_woken_id;
        n_last       = r_last;
        wr_en        = 1'b0;
        wr_idx       = r_count[IDX_W-1:0];
        wr_id        = in_id;
        wr_wake      = add_sum[TIME_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                n_rd_idx     = '0;
                n_keep       = '0;
                n_pend_valid = 1'b0;
                if (accept && (t_cmd'(i_command) == CMD_SLEEP)) begin
                    n_strobe   = 1'b1;
                    n_woken_id = 8'(in_id);
                    n_last     = 1'b1;
                    if (full) begin
                        n_kind = KIND_REJECT;
                    end else begin
                        n_kind  = KIND_ACCEPT;
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    n_rd_idx   = r_rd_idx + 1'b1;
                    n_rd_valid = 1'b1;
                end
                if (r_rd_valid) begin
                    if (due) begin
                        // Emit the previously found thread; this one waits so
                        // that the final result can be marked.
                        if (r_pend_valid) begin
                            n_strobe   = 1'b1;
                            n_kind     = KIND_WAKE;
                            n_woken_id = 8'(r_pend_id);
                            n_last     = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = r_rd_id;
                    end else begin
                        wr_en   = 1'b1;
                        wr_idx  = r_keep[IDX_W-1:0];
                        wr_id   = r_rd_id;
                        wr_wake = r_rd_wake;
                        n_keep  = r_keep + 1'b1;
                    end
                end else if (!rd_issue) begin
                    n_count      = r_keep;
                    n_pend_valid = 1'b0;
                    if (r_pend_valid) begin
                        n_strobe   = 1'b1;
                        n_kind     = KIND_WAKE;
                        n_woken_id = 8'(r_pend_id);
                        n_last     = 1'b1;
                    end
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_rd_idx     <= '0;
            r_keep       <= '0;
            r_rd_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rd_idx     <= n_rd_idx;
            r_keep       <= n_keep;
            r_rd_valid   <= n_rd_valid;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id  <= n_pend_id;
        r_kind     <= n_kind;
        r_woken_id <= n_woken_id;
        r_last     <= n_last;
        if (accept) begin
            r_now <= i_now;
        end
    end

    // Queue memory: one write port, one registered read port. A compaction
    // write always lands below the entry being read, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_id[wr_idx]   <= wr_id;
            r_mem_wake[wr_idx] <= wr_wake;
        end
        if (rd_issue) begin
            r_rd_id   <= r_mem_id[r_rd_idx[IDX_W-1:0]];
            r_rd_wake <= r_mem_wake[r_rd_idx[IDX_W-1:0]];
        end
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_woken_id = r_woken_id;
    assign o_last     = r_last;

endmodule

FILE: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdq_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = MAX_SLEEPERS + 8;
    localparam logic [31:0] TIME_MIN      = 32'h8000_0000;
    localparam logic [31:0] TIME_MAX      = 32'h7FFF_FFFF;
    localparam logic [30:0] DUR_MAX       = 31'h7FFF_FFFF;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] id;
        logic       last;
    } t_notice;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    logic                     i_command   = 1'b0;
    logic [7:0]               i_thread_id = '0;
    logic [DUR_W-1:0]         i_duration  = '0;
    logic signed [TIME_W-1:0] i_now       = '0;
    logic                     o_strobe;
    logic [KIND_W-1:0]        o_kind;
    logic [7:0]               o_woken_id;
    logic                     o_last;

    // Shadow copy of the sleep queue, updated as each item is accepted.
    logic [7:0]  sleeper_id   [MAX_SLEEPERS];
    logic [31:0] sleeper_wake [MAX_SLEEPERS];
    int          sleeper_count = 0;

    t_notice     notice_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic [31:0] timer_now   = '0;
    bit          no_idle     = 1'b0;

    sleep_deadline_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_thread_id (i_thread_id),
        .i_duration  (i_duration),
        .i_now       (i_now),
        .o_strobe    (o_strobe),
        .o_kind      (o_kind),
        .o_woken_id  (o_woken_id),
        .o_last      (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Works out the notices one item produces and updates the shadow queue.
    function automatic void apply_item_to_sleepers(t_cmd cmd, logic [7:0] id,
                                                   logic [30:0] dur, logic [31:0] now);
        int      keep;
        int      woken;
        t_notice tail;
        keep  = 0;
        woken = 0;
        if (cmd == CMD_SLEEP) begin
            if (sleeper_count >= MAX_SLEEPERS) begin
                notice_q.push_back('{KIND_REJECT, id, 1'b1});
            end else begin
                sleeper_id[sleeper_count]   = id;
                sleeper_wake[sleeper_count] = now + {1'b0, dur};
                sleeper_count++;
                notice_q.push_back('{KIND_ACCEPT, id, 1'b1});
            end
        end else begin
            for (int i = 0; i < sleeper_count; i++) begin
                if ($signed(sleeper_wake[i]) <= $signed(now)) begin
                    notice_q.push_back('{KIND_WAKE, sleeper_id[i], 1'b0});
                    woken++;
                end else begin
                    sleeper_id[keep]   = sleeper_id[i];
                    sleeper_wake[keep] = sleeper_wake[i];
                    keep++;
                end
            end
            sleeper_count = keep;
            if (woken > 0) begin
                tail = notice_q.pop_back();
                tail.last = 1'b1;
                notice_q.push_back(tail);
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_notices
        t_notice want;
        if (i_rst_n && o_strobe) begin
            if (notice_q.size() == 0) begin
                $error("unexpected result: kind %0d woken_id %0d last %0d",
                       o_kind, o_woken_id, o_last);
                error_count++;
            end else begin
                want = notice_q.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    error_count++;
                end
                if (o_woken_id !== want.id) begin
                    $error("woken_id: expected %0d, got %0d", want.id, o_woken_id);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(t_cmd cmd, logic [7:0] id, logic [30:0] dur,
                             logic [31:0] now, int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        i_command   = cmd;
        i_thread_id = id;
        i_duration  = dur;
        i_now       = now;
        start       = 1'b1;
        do @(posedge i_clk); while (busy);
        apply_item_to_sleepers(cmd, id, dur, now);
    endtask

    task automatic wait_for_notices();
        @(negedge i_clk);
        start = 1'b0;
        while (notice_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // Empty queue, then the extreme times and the signed wrap of a wake time.
        send_item(CMD_CHECK, 8'd0, 31'd0, 32'd0, 2);
        send_item(CMD_SLEEP, 8'd0, 31'd0, TIME_MIN, $urandom_range(0, 3));
        send_item(CMD_SLEEP, 8'd255, DUR_MAX, TIME_MAX, $urandom_range(0, 3));
        send_item(CMD_CHECK, 8'd0, 31'd0, TIME_MIN, $urandom_range(0, 3));
        send_item(CMD_CHECK, 8'd0, 31'd0, 32'hFFFF_FFFD, $urandom_range(0, 3));
        send_item(CMD_CHECK, 8'd0, 31'd0, 32'hFFFF_FFFE, $urandom_range(0, 3));
        // Fill the queue with interleaved early and late sleepers, then overflow it.
        for (int i = 0; i < MAX_SLEEPERS; i++) begin
            send_item(CMD_SLEEP, 8'(i * 17), (i % 2) ? 31'(100 + i) : 31'(1000 + i),
                      32'd0, $urandom_range(0, 3));
        end
        send_item(CMD_SLEEP, 8'h5A, 31'd7, 32'd0, $urandom_range(0, 3));
        // The early half wakes and the late half is compacted behind it.
        send_item(CMD_CHECK, 8'd0, 31'd0, 32'd500, $urandom_range(0, 3));
        send_item(CMD_SLEEP, 8'hC3, 31'd0, 32'd600, $urandom_range(0, 3));
        send_item(CMD_CHECK, 8'd0, 31'd0, TIME_MAX, $urandom_range(0, 3));
    endtask

    task automatic test_random_traffic(int n_items, int unsigned sleep_pct, bit no_gaps);
        t_cmd        cmd;
        logic [30:0] dur;
        logic [31:0] now;
        int unsigned gap;
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
            gap = (no_gaps || no_idle) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0) timer_now = $urandom();
            timer_now += $urandom_range(0, 60);
            now = timer_now;
            // Now and then a stray time far from the running timer.
            if ($urandom_range(0, 19) == 0) now = $urandom();
            case ($urandom_range(0, 9))
                0:       dur = 31'($urandom());
                1:       dur = 31'd0;
                default: dur = 31'($urandom_range(0, 300));
            endcase
            cmd = ($urandom_range(0, 99) < sleep_pct) ? CMD_SLEEP : CMD_CHECK;
            send_item(cmd, 8'($urandom_range(0, 255)), dur, now, gap);
        end
    endtask

    task automatic test_fill_and_drain();
        // Sleep-heavy traffic keeps the queue near full, then the sender holds off.
        test_random_traffic(60, 75, 1'b0);
        wait_for_notices();
    endtask

    task automatic test_back_to_back();
        // Start near the signed boundary so wake times and the timer both wrap.
        timer_now = 32'h7FFF_FF00;
        test_random_traffic(30, 60, 1'b1);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_fill_and_drain();
        test_back_to_back();
        test_random_traffic(54, 55, 1'b0);

        wait_for_notices();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sleep_deadline_queue_unit.f
rtl/sdq_pkg.sv
rtl/sleep_deadline_queue_unit.sv
bench/tb_top.sv
